>>> hw/rtl/planar_tile_dedup_packer_macros.svh
// Assertion macros used by the tile dedup packer checker.
`ifndef PLANAR_TILE_DEDUP_PACKER_MACROS_SVH
`define PLANAR_TILE_DEDUP_PACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tdp_pkg.sv
// Package: sizes, status codes and row packing for the tile dedup packer.
package tdp_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int TILES_ACROSS = 32;
  localparam int TILES_DOWN   = 30;
  localparam int TOTAL_SLOTS  = TILES_ACROSS * TILES_DOWN;

  // Fixed field widths
  localparam int PIX_W     = 16;
  localparam int ROW_W     = 3;
  localparam int PLANE_W   = 64;
  localparam int ENTRY_W   = 2 * PLANE_W;
  localparam int TIDX_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int SPOS_W    = 10;
  localparam int UCOUNT_W  = 9;

  // Widths derived from the table and screen sizes
  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IDX_W   = (ADDR_W > TIDX_W) ? ADDR_W : TIDX_W;
  localparam int CNT_RAW = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W   = (CNT_RAW > UCOUNT_W) ? CNT_RAW : UCOUNT_W;
  localparam int SLOT_RAW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int SLOT_W  = (SLOT_RAW > SPOS_W) ? SLOT_RAW : SPOS_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

  // Row events from the packer to the controller
  typedef struct packed {
    logic frame_start;
    logic tile_go;
  } row_ev_t;

  // Table memory access
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // Split one row of 2-bit pixels into its two plane bytes {high, low}
  function automatic logic [15:0] pack_row(input logic [PIX_W-1:0] pix);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = '0;
    b1 = '0;
    for (int x = 0; x < 8; x++) begin
      b0[7-x] = pix[2*x];
      b1[7-x] = pix[2*x+1];
    end
    return {b1, b0};
  endfunction

endpackage

>>> hw/rtl/planar_tile_dedup_packer.sv
// Top level of the planar tile dedup packer.
//
// Input channel: one item per tile row (eight 2-bit pixels plus frame_start),
// eight rows make a tile. Rows 0..6 are taken one per cycle while in_stall is low and give no result.
// The eighth row starts a search of the unique-tile table, one stored entry
// per cycle through the table memory's single read port; in_stall stays high
// meanwhile. A miss reads every stored entry before the insert, a hit stops
// at the first matching entry, and the result then waits in S_EMIT for the
// output register.
// Result channel: one item per tile with the index, status, screen slot,
// both planes, the unique count and the frame-done flag, from an output
// register. A new tile's rows are taken while a result still waits there;
// if the receiver stalls, the next result waits in the controller and the
// input stays stalled until the register frees up.
// Reset clears row, slot, count, overflow and the output valid. The table
// memory is not cleared: only entries below the count are ever read, and
// frame_start resets the count.
module planar_tile_dedup_packer import tdp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIX_W-1:0]    in_row_pixels,
  input  logic                in_frame_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TIDX_W-1:0]   out_tile_index,
  output logic [STATUS_W-1:0] out_status,
  output logic [SPOS_W-1:0]   out_screen_position,
  output logic [PLANE_W-1:0]  out_plane_low,
  output logic [PLANE_W-1:0]  out_plane_high,
  output logic [UCOUNT_W-1:0] out_unique_count,
  output logic                out_frame_done
);

  logic               busy;
  logic               in_fire;
  row_ev_t            ev;
  mem_req_t           mem_req;
  logic [PLANE_W-1:0] plane_low;
  logic [PLANE_W-1:0] plane_high;
  logic [ENTRY_W-1:0] rd_data;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  // Pack rows into planes
  tdp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .row_pixels  (in_row_pixels),
    .frame_start (in_frame_start),
    .ev          (ev),
    .plane_low   (plane_low),
    .plane_high  (plane_high)
  );

  // Unique-tile table
  tdp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // Search, insert and result
  tdp_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ev                  (ev),
    .plane_low           (plane_low),
    .plane_high          (plane_high),
    .rd_data             (rd_data),
    .mem_req             (mem_req),
    .busy                (busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tile_index      (out_tile_index),
    .out_status          (out_status),
    .out_screen_position (out_screen_position),
    .out_plane_low       (out_plane_low),
    .out_plane_high      (out_plane_high),
    .out_unique_count    (out_unique_count),
    .out_frame_done      (out_frame_done)
  );

endmodule

>>> hw/rtl/tdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tdp_pack.sv
// Row packer: bit-plane accumulators and row counter.
module tdp_pack import tdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [PIX_W-1:0]   row_pixels,
  input  logic               frame_start,
  output row_ev_t            ev,
  output logic [PLANE_W-1:0] plane_low,
  output logic [PLANE_W-1:0] plane_high
);

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   row_eff;
  logic [PLANE_W-1:0] low_r, low_nxt;
  logic [PLANE_W-1:0] high_r, high_nxt;
  logic [15:0]        bytes;

  // Pick the row slot: frame start forces row zero
  always_comb begin
    row_eff = frame_start ? '0 : row_r;
    bytes   = pack_row(row_pixels);
  end

  // Replace the row's byte in each plane (clearing both on frame start), advance the row
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    row_nxt  = row_r;
    if (fire) begin
      if (frame_start) begin
        low_nxt  = '0;
        high_nxt = '0;
      end
      low_nxt[8*row_eff +: 8]  = bytes[7:0];
      high_nxt[8*row_eff +: 8] = bytes[15:8];
      row_nxt = row_eff + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else begin
      row_r  <= row_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // Flag frame start and the last row of a tile
  always_comb begin
    ev.frame_start = fire && frame_start;
    ev.tile_go     = fire && (row_eff == {ROW_W{1'b1}});
  end

  assign plane_low  = low_r;
  assign plane_high = high_r;

endmodule

>>> hw/rtl/tdp_ctrl.sv
// Search controller: table scan, insert, frame counters and result register.
module tdp_ctrl import tdp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  row_ev_t             ev,
  input  logic [PLANE_W-1:0]  plane_low,
  input  logic [PLANE_W-1:0]  plane_high,
  input  logic [ENTRY_W-1:0]  rd_data,
  output mem_req_t            mem_req,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TIDX_W-1:0]   out_tile_index,
  output logic [STATUS_W-1:0] out_status,
  output logic [SPOS_W-1:0]   out_screen_position,
  output logic [PLANE_W-1:0]  out_plane_low,
  output logic [PLANE_W-1:0]  out_plane_high,
  output logic [UCOUNT_W-1:0] out_unique_count,
  output logic                out_frame_done
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    stored_r, stored_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]    index_r, index_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                oval_r, oval_nxt;
  logic                out_free;
  logic                last_slot;
  logic                hit;

  logic [TIDX_W-1:0]   o_idx_r;
  logic [STATUS_W-1:0] o_st_r;
  logic [SPOS_W-1:0]   o_pos_r;
  logic [PLANE_W-1:0]  o_low_r;
  logic [PLANE_W-1:0]  o_high_r;
  logic [UCOUNT_W-1:0] o_cnt_r;
  logic                o_done_r;

  assign out_free  = !oval_r || !out_stall;
  assign last_slot = (slot_r == SLOT_W'(TOTAL_SLOTS - 1));
  assign hit       = chk_vld_r && (rd_data == {plane_high, plane_low});

  // Sequence one tile: scan stored entries one read per cycle, stop on a match, else insert or flag overflow
  always_comb begin
    state_nxt   = state_r;
    stored_nxt  = stored_r;
    slot_nxt    = slot_r;
    ovf_nxt     = ovf_r;
    issue_nxt   = issue_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    index_nxt   = index_r;
    status_nxt  = status_r;
    oval_nxt    = oval_r && out_stall;
    mem_req     = '0;
    mem_req.waddr = stored_r[ADDR_W-1:0];
    mem_req.wdata = {plane_high, plane_low};
    mem_req.raddr = issue_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        // Clear frame state on frame start
        if (ev.frame_start) begin
          stored_nxt = '0;
          slot_nxt   = '0;
          ovf_nxt    = 1'b0;
        end
        if (ev.tile_go) begin
          if (ovf_r) begin
            index_nxt  = '0;
            status_nxt = ST_OVF;
            state_nxt  = S_EMIT;
          end else begin
            issue_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Stop on the first matching entry
          index_nxt  = IDX_W'(chk_idx_r);
          status_nxt = ST_MATCH;
          state_nxt  = S_EMIT;
        end else if (issue_r < stored_r) begin
          // Issue the next read
          mem_req.re  = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[ADDR_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end else if (!chk_vld_r) begin
          // Scan exhausted: insert or overflow
          if (stored_r >= CNT_W'(TABLE_DEPTH)) begin
            ovf_nxt    = 1'b1;
            index_nxt  = '0;
            status_nxt = ST_OVF;
          end else begin
            mem_req.we = 1'b1;
            index_nxt  = IDX_W'(stored_r[ADDR_W-1:0]);
            status_nxt = ST_NEW;
            stored_nxt = stored_r + CNT_W'(1);
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Load the result once the output register is free
        if (out_free) begin
          oval_nxt  = 1'b1;
          slot_nxt  = last_slot ? '0 : slot_r + SLOT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      stored_r  <= '0;
      slot_r    <= '0;
      ovf_r     <= 1'b0;
      issue_r   <= '0;
      chk_vld_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stored_r  <= stored_nxt;
      slot_r    <= slot_nxt;
      ovf_r     <= ovf_nxt;
      issue_r   <= issue_nxt;
      chk_vld_r <= chk_vld_nxt;
      oval_r    <= oval_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    index_r   <= index_nxt;
    status_r  <= status_nxt;
    if (state_r == S_EMIT && out_free) begin
      o_idx_r  <= index_r[TIDX_W-1:0];
      o_st_r   <= status_r;
      o_pos_r  <= slot_r[SPOS_W-1:0];
      o_low_r  <= plane_low;
      o_high_r <= plane_high;
      o_cnt_r  <= stored_r[UCOUNT_W-1:0];
      o_done_r <= last_slot;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = oval_r;
  assign out_tile_index      = o_idx_r;
  assign out_status          = o_st_r;
  assign out_screen_position = o_pos_r;
  assign out_plane_low       = o_low_r;
  assign out_plane_high      = o_high_r;
  assign out_unique_count    = o_cnt_r;
  assign out_frame_done      = o_done_r;

endmodule

>>> hw/rtl/tdp_checker.sv
// Port-level checker for the tile dedup packer, bound to the top level.
`include "planar_tile_dedup_packer_macros.svh"

module tdp_checker import tdp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [TIDX_W-1:0]   out_tile_index,
  input logic [STATUS_W-1:0] out_status,
  input logic [SPOS_W-1:0]   out_screen_position,
  input logic [PLANE_W-1:0]  out_plane_low,
  input logic [PLANE_W-1:0]  out_plane_high,
  input logic [UCOUNT_W-1:0] out_unique_count,
  input logic                out_frame_done
);

  logic [TIDX_W+STATUS_W+SPOS_W+2*PLANE_W+UCOUNT_W:0] out_payload;

  // Gather the whole result item
  assign out_payload = {out_tile_index, out_status, out_screen_position, out_plane_low,
                        out_plane_high, out_unique_count, out_frame_done};

  // Hold a stalled result
  `TDP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled item dropped")

  `TDP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_payload), "stalled item changed")

  // A new tile takes the last index
  `TDP_ASSERT_NOW(a_new_idx, clk, rst_n, out_valid && out_status == ST_NEW, {1'b0, out_tile_index} == (out_unique_count - UCOUNT_W'(1)), "new tile index mismatch")

  // Overflow reports index zero
  `TDP_ASSERT_NOW(a_ovf_idx, clk, rst_n, out_valid && out_status == ST_OVF, out_tile_index == '0, "overflow index not zero")

  // A match never exceeds the count
  `TDP_ASSERT_NOW(a_match_idx, clk, rst_n, out_valid && out_status == ST_MATCH, {1'b0, out_tile_index} < out_unique_count, "match index beyond count")

endmodule

bind planar_tile_dedup_packer tdp_checker u_tdp_checker (.*);
